/* rtl/oqkr_pkg.sv */
package oqkr_pkg;

  // Defaults and fixed key geometry
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_BYTES       = 24;
  localparam int KEY_WORDS       = 3;
  localparam int KEY_W           = 64 * KEY_WORDS;

  // Request codes
  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key_word_lo;
    logic [63:0] key_word_mid;
    logic [63:0] key_word_hi;
  } req_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position_before;
    logic [4:0] entry_count;
  } rsp_word_t;

endpackage

/* rtl/ordered_queue_keyed_remove.sv */
// Enqueue, unused request types, empty-queue and full-queue requests go from S_IDLE straight
// to S_RESP, which loads the result register once it is free. Remove/query scan from the head;
// a removal then copies every entry behind the match down by one to close the gap.
// One word in flight at a time; the single read port of the key memory paces scan and shift.
// Reset (rst_n, synchronous) empties the queue; key memory contents are not cleared.
module ordered_queue_keyed_remove
  import oqkr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  req_word_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rsp_word_t out_data
);

  // Address width of the key memory, count width able to hold the depth itself
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  // Control state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;          // read index: scan entry or shift source
  logic            tag_v_r, tag_v_nxt;      // read data in rd_data_r is live
  logic            out_valid_r, out_valid_nxt;

  // Payload state
  logic [CW-1:0]   tag_idx_r, tag_idx_nxt;  // entry that rd_data_r came from
  logic [KEY_W-1:0] key_r, key_nxt;
  logic            is_remove_r, is_remove_nxt;
  logic [1:0]      res_status_r, res_status_nxt;
  logic [CW-1:0]   res_pos_r, res_pos_nxt;
  rsp_word_t       out_word_r, out_word_nxt;

  // Key memory, one write and one registered read per cycle
  logic [KEY_W-1:0] key_mem_r [QUEUE_DEPTH];
  logic [KEY_W-1:0] rd_data_r;
  logic             rd_issue;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;

  logic [KEY_W-1:0] norm_key;
  logic [KEY_W-1:0] raw_key;
  logic             in_fire;
  logic             key_hit;
  logic [CW-1:0]    tag_next;
  logic [31:0]      pos_ext;
  logic [31:0]      cnt_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Normalise the key: the name ends at its first zero byte or at KEY_BYTES;
  // everything from there on reads as zero.
  assign raw_key = {in_data.key_word_hi, in_data.key_word_mid, in_data.key_word_lo};

  always_comb begin
    logic ended;
    ended    = 1'b0;
    norm_key = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (b >= KEY_BYTES || raw_key[8*b +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        norm_key[8*b +: 8] = raw_key[8*b +: 8];
      end
    end
  end

  // In the scan or shift state, issue a read whenever the index still points inside the queue
  assign rd_issue = ((state_r == S_SCAN) || (state_r == S_SHIFT)) && (idx_r < count_r);
  assign key_hit  = (rd_data_r == key_r);
  assign tag_next = CW'(tag_idx_r + CW'(1));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    tag_v_nxt      = 1'b0;
    tag_idx_nxt    = tag_idx_r;
    key_nxt        = key_r;
    is_remove_nxt  = is_remove_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];
    wr_data        = norm_key;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt        = norm_key;
          is_remove_nxt  = (in_data.req_type == REQ_REMOVE);
          res_pos_nxt    = '0;
          res_status_nxt = ST_DONE;
          idx_nxt        = '0;
          state_nxt      = S_RESP;
          case (in_data.req_type)
            REQ_ENQUEUE: begin
              if (count_r == CW'(QUEUE_DEPTH)) begin
                res_status_nxt = ST_FULL;        // drop the key
              end else begin
                wr_en     = 1'b1;                // append at the tail
                count_nxt = CW'(count_r + CW'(1));
              end
            end
            REQ_REMOVE, REQ_QUERY: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // unused request type: no change, status done
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_issue) begin
          idx_nxt     = CW'(idx_r + CW'(1));
          tag_v_nxt   = 1'b1;
          tag_idx_nxt = idx_r;
        end
        if (tag_v_r) begin
          if (key_hit) begin
            res_status_nxt = ST_DONE;
            tag_v_nxt      = 1'b0;
            if (!is_remove_r) begin
              res_pos_nxt = tag_idx_r;
              state_nxt   = S_RESP;
            end else if (tag_next < count_r) begin
              // close the gap: copy every later entry down by one
              idx_nxt   = tag_next;
              state_nxt = S_SHIFT;
            end else begin
              count_nxt = CW'(count_r - CW'(1));
              state_nxt = S_RESP;
            end
          end else if (tag_next == count_r) begin
            res_status_nxt = ST_NOT_FOUND;
            tag_v_nxt      = 1'b0;
            state_nxt      = S_RESP;
          end
        end
      end

      S_SHIFT: begin
        if (rd_issue) begin
          idx_nxt     = CW'(idx_r + CW'(1));
          tag_v_nxt   = 1'b1;
          tag_idx_nxt = idx_r;
        end
        if (tag_v_r) begin
          wr_en   = 1'b1;
          wr_addr = AW'(tag_idx_r - CW'(1));
          wr_data = rd_data_r;
        end else if (idx_r == count_r) begin
          count_nxt = CW'(count_r - CW'(1));
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_word_nxt.status          = res_status_r;
          out_word_nxt.position_before = pos_ext[3:0];
          out_word_nxt.entry_count     = cnt_ext[4:0];
          state_nxt                    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign pos_ext = 32'(res_pos_r);
  assign cnt_ext = 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      tag_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      tag_v_r     <= tag_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_idx_r    <= tag_idx_nxt;
    key_r        <= key_nxt;
    is_remove_r  <= is_remove_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_word_r   <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data_r <= key_mem_r[idx_r[AW-1:0]];
    end
  end

  // Checks
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("accepted a second word while busy");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside the response step");

  a_shift_write_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_SHIFT) |-> (CW'(wr_addr) < count_r))
    else $error("shift writes beyond the queue tail");

  a_enqueue_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.req_type == REQ_ENQUEUE && count_r != CW'(QUEUE_DEPTH))
    |=> (count_r == CW'($past(count_r) + CW'(1))))
    else $error("enqueue did not advance the count");

endmodule
